// ----- hdl/b2da_pkg.sv -----
// Shared types, constants and sizing functions for the binary to decimal ASCII converter.
// No dependencies; every other file of the block imports this package.
package b2da_pkg;

  // Default configuration of the block.
  localparam int VALUE_WIDTH_DEF     = 64;
  localparam int FRACTION_DIGITS_DEF = 5;

  // Value bits folded into the BCD register per conversion cycle.
  localparam int BITS_PER_STEP = 4;

  // ASCII codes that the block emits.
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_NINE = 7'h39;
  localparam logic [6:0] ASCII_DOT  = 7'h2E;

  // Operation codes.
  typedef enum logic {
    OP_INTEGER = 1'b0,
    OP_FIXED   = 1'b1
  } op_t;

  // One input beat.
  typedef struct packed {
    logic [63:0] value;
    op_t         operation;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new value and clear the BCD register
    logic dabble;  // fold the next bits of the value into the BCD register
    logic shift;   // drop the top BCD digit
    logic emit;    // write a character into the output register
    logic dot;     // the emitted character is the decimal point
    logic last;    // the emitted character ends the number
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic top_zero;  // the top BCD digit is zero
  } ctl_stat_t;

  // Decimal digits of the largest w-bit value: floor(w * log10(2)) + 1.
  function automatic int value_digits(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

  // BCD digits held: enough for the value and for the fixed-point minimum of f + 1.
  function automatic int bcd_digits(input int w, input int f);
    return (value_digits(w) > f) ? value_digits(w) : f + 1;
  endfunction

endpackage

// ----- hdl/b2da_datapath.sv -----
// Datapath of the converter: value shift register, BCD register with add-3 correction,
// and the registered character output. Depends on b2da_pkg.
module b2da_datapath #(
  parameter int VALUE_WIDTH     = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_DIGITS = b2da_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                clk,
  input  logic [63:0]         in_value,
  input  b2da_pkg::ctl_cmd_t  cmd,
  output b2da_pkg::ctl_stat_t stat,
  output b2da_pkg::out_t      out_data
);
  import b2da_pkg::*;

  localparam int CONV_STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_BITS = CONV_STEPS * BITS_PER_STEP;
  localparam int BCD_DIGITS = bcd_digits(VALUE_WIDTH, FRACTION_DIGITS);
  localparam int BCD_BITS   = 4 * BCD_DIGITS;

  logic [SHIFT_BITS-1:0] value_r, value_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt, bcd_dabble;
  out_t                  out_r, out_nxt;
  logic [3:0]            top_digit;

  assign top_digit     = bcd_r[BCD_BITS-1 -: 4];
  assign stat.top_zero = (top_digit == 4'd0);

  // Double dabble over one nibble of the value, most significant bit first.
  always_comb begin
    logic [BCD_BITS-1:0] acc;
    acc = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_BITS-2:0], value_r[SHIFT_BITS-1-s]};
    end
    bcd_dabble = acc;
  end

  // Next values of the value and BCD registers.
  always_comb begin
    value_nxt = value_r;
    bcd_nxt   = bcd_r;
    if (cmd.load) begin
      value_nxt = SHIFT_BITS'(in_value[VALUE_WIDTH-1:0]);
      bcd_nxt   = '0;
    end else if (cmd.dabble) begin
      value_nxt = value_r << BITS_PER_STEP;
      bcd_nxt   = bcd_dabble;
    end else if (cmd.shift) begin
      bcd_nxt = bcd_r << 4;
    end
  end

  // Character for the output register.
  always_comb begin
    out_nxt = out_r;
    if (cmd.emit) begin
      out_nxt.character = cmd.dot ? ASCII_DOT : 7'(ASCII_ZERO + {3'b000, top_digit});
      out_nxt.last      = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    bcd_r   <= bcd_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- hdl/b2da_ctrl.sv -----
// Controller of the converter: sequences conversion, leading-zero skip and character
// emission, and drives the result strobe. Depends on b2da_pkg.
module b2da_ctrl #(
  parameter int VALUE_WIDTH     = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_DIGITS = b2da_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  b2da_pkg::op_t       in_operation,
  input  b2da_pkg::ctl_stat_t stat,
  output b2da_pkg::ctl_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import b2da_pkg::*;

  localparam int CONV_STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int BCD_DIGITS = bcd_digits(VALUE_WIDTH, FRACTION_DIGITS);
  localparam int CW         = $clog2(CONV_STEPS);
  localparam int RW         = $clog2(BCD_DIGITS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] min_rem;
  op_t           op_r, op_nxt;
  logic          dot_done_r, dot_done_nxt;
  logic          out_valid_r;

  // Digits that always print: one in integer mode, the fraction plus one in fixed mode.
  assign min_rem = (op_r == OP_FIXED) ? RW'(FRACTION_DIGITS + 1) : RW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      op_r        <= OP_INTEGER;
      dot_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      op_r        <= op_nxt;
      dot_done_r  <= dot_done_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    op_nxt       = op_r;
    dot_done_nxt = dot_done_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          op_nxt    = in_operation;
          cnt_nxt   = CW'(CONV_STEPS - 1);
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.dabble = 1'b1;
        if (cnt_r == '0) begin
          rem_nxt      = RW'(BCD_DIGITS);
          dot_done_nxt = 1'b0;
          state_nxt    = ST_SKIP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros one digit a cycle.
        if (stat.top_zero && (rem_r > min_rem)) begin
          cmd.shift = 1'b1;
          rem_nxt   = rem_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if ((op_r == OP_FIXED) && (rem_r == RW'(FRACTION_DIGITS)) && !dot_done_r) begin
          cmd.dot      = 1'b1;
          dot_done_nxt = 1'b1;
        end else begin
          cmd.shift = 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == RW'(1)) begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// Top level of the binary to decimal ASCII converter: controller plus datapath.
// Depends on b2da_pkg, b2da_ctrl and b2da_datapath.
//
// A number is taken when start is high and busy is low. Its decimal text comes out
// one character per out_valid beat, most significant first, last set on the final
// one; the receiver cannot stall and must take every beat. The value is converted
// to BCD four bits per cycle, then leading zeros are dropped one digit per cycle and
// the characters are emitted. busy stays high from the accepted number until the final
// character is written to the output register; the BCD register holds 20 digits for
// the default 64-bit value, and in fixed-point mode the decimal point adds one more
// character. A new number is taken only once busy is low again.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH     = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_DIGITS = b2da_pkg::FRACTION_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  b2da_pkg::in_t  in_data,
  output logic           out_valid,
  output b2da_pkg::out_t out_data
);
  import b2da_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  b2da_ctrl #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_data.operation),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  b2da_datapath #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_datapath (
    .clk     (clk),
    .in_value(in_data.value),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule

// ----- hdl/b2da_checker.sv -----
// Port-level checks of the converter's beat sequencing, bound to the top level.
// Depends on b2da_pkg and binary_to_decimal_ascii.
module b2da_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input b2da_pkg::in_t  in_data,
  input logic           out_valid,
  input b2da_pkg::out_t out_data
);
  import b2da_pkg::*;

  // An accepted number makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted number");

  // Every result beat follows a busy cycle.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a number in progress");

  // The final character frees the block; earlier characters keep it busy.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> !busy)
    else $error("block still busy after the final character");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> busy)
    else $error("block went idle before the final character");

  // Only digits and the decimal point are emitted.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.character == ASCII_DOT) ||
                   ((out_data.character >= ASCII_ZERO) &&
                    (out_data.character <= ASCII_NINE))))
    else $error("emitted character is neither a digit nor a point");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

// ----- bench/b2da_text_checker.sv -----
// Checker for the binary to decimal ASCII converter: watches both channels and predicts the text.
// Depends on b2da_pkg; the bench top instantiates it beside the block.
`timescale 1ns / 1ps

module b2da_text_checker #(
  parameter int VALUE_WIDTH     = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_DIGITS = b2da_pkg::FRACTION_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  b2da_pkg::in_t  in_data,
  input  logic           out_valid,
  input  b2da_pkg::out_t out_data,
  output int             pending_chars,
  output int             fail_count
);
  import b2da_pkg::*;

  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? ~64'd0 : ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam int REPORT_LIMIT = 10;

  // Characters still owed by the block, oldest first.
  out_t expected_text[$];
  int   mismatches = 0;

  initial begin
    pending_chars = 0;
    fail_count    = 0;
  end

  // Appends the decimal text of one number to the expected characters.
  task automatic predict_text(input in_t item);
    logic [63:0] v;
    logic [6:0]  rev[$];
    int          d;
    int          i;
    v = item.value & VALUE_MASK;
    // Fixed point: the fraction digits come out first in reverse, leading zeros kept.
    if (item.operation == OP_FIXED) begin
      for (d = 0; d < FRACTION_DIGITS; d++) begin
        rev.push_back(ASCII_ZERO + 7'(v % 64'd10));
        v = v / 64'd10;
      end
      rev.push_back(ASCII_DOT);
    end
    // Integer digits, at least one.
    do begin
      rev.push_back(ASCII_ZERO + 7'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 64'd0);
    for (i = rev.size() - 1; i >= 0; i--) begin
      expected_text.push_back('{character: rev[i], last: (i == 0)});
    end
  endtask

  // Sample both channels at each edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected beat char=%h last=%b", $realtime,
                     out_data.character, out_data.last);
        end else begin
          want = expected_text.pop_front();
          if (out_data.character !== want.character || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b", $realtime,
                       want.character, out_data.character, want.last, out_data.last);
          end
        end
      end
      if (start && !busy) predict_text(in_data);
    end
    pending_chars <= expected_text.size();
    fail_count    <= mismatches;
  end

endmodule

// ----- bench/binary_to_decimal_ascii_tb.sv -----
// Bench top for the binary to decimal ASCII converter: clock, reset, stimulus and verdict.
// Depends on b2da_pkg, binary_to_decimal_ascii and b2da_text_checker.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 60;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   pending_chars;
  int   fail_count;
  int   idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_to_decimal_ascii u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  b2da_text_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .pending_chars(pending_chars),
    .fail_count   (fail_count)
  );

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] power_of_ten(input int k);
    logic [63:0] p;
    int          i;
    p = 64'd1;
    for (i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Offers one number after a gap and returns at the edge that takes it.
  task automatic send_number(input logic [63:0] value, input op_t op, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{value: value, operation: op};
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every expected character has come out.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
  endtask

  // Random values spread over digit counts, powers of ten and full-width patterns.
  function automatic logic [63:0] random_value();
    logic [63:0] wide;
    int          k;
    wide = {$urandom, $urandom};
    k    = $urandom_range(0, 19);
    case ($urandom_range(0, 5))
      0: return wide;
      1: return 64'($urandom_range(0, 999));
      2: return (k == 0) ? wide : wide % power_of_ten(k);
      3: return power_of_ten(k) + 64'($urandom_range(0, 2)) - 64'd1;
      4: return 64'($urandom_range(0, 9999999));
      default: return ~64'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int  n;
    int  gap;
    bit  burst;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed numbers: zeros, digit boundaries, fraction edges and the widest texts.
    send_number(64'd0, OP_INTEGER, 0);
    send_number(64'd0, OP_FIXED, 0);
    send_number(64'd1, OP_INTEGER, 1);
    send_number(64'd1, OP_FIXED, 0);
    send_number(64'd9, OP_INTEGER, 3);
    send_number(64'd10, OP_INTEGER, 0);
    send_number(64'd9, OP_FIXED, 2);
    send_number(64'd12345, OP_FIXED, 0);
    send_number(64'd99999, OP_FIXED, 0);
    send_number(64'd100000, OP_FIXED, 5);
    send_number(64'd100001, OP_FIXED, 0);
    send_number(64'd1234567890, OP_INTEGER, 0);
    send_number(power_of_ten(19) - 64'd1, OP_INTEGER, 7);
    send_number(power_of_ten(19), OP_INTEGER, 0);
    send_number(~64'd0, OP_INTEGER, 0);
    send_number(~64'd0, OP_FIXED, 0);
    send_number(64'h8000_0000_0000_0000, OP_INTEGER, 4);
    send_number(64'h8000_0000_0000_0000, OP_FIXED, 0);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, OP_INTEGER, 0);
    send_number(64'h5555_5555_5555_5555, OP_FIXED, 1);
    send_number(64'd1000000, OP_FIXED, 0);
    wait_drained();

    // Random numbers, with bursts of back-to-back beats and two full drains.
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 120 || n == 240) wait_drained();
      gap = burst ? 0 : $urandom_range(0, 7);
      send_number(random_value(), op_t'($urandom_range(0, 1)), gap);
    end

    // Let the last text come out, then watch for stray beats.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/b2da_pkg.sv
hdl/b2da_datapath.sv
hdl/b2da_ctrl.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_checker.sv
bench/b2da_text_checker.sv
bench/binary_to_decimal_ascii_tb.sv
